// ===== rtl/turn_then_drive_goal_controller_top_macros.svh =====
// Assertion helpers for the goal controller.
`ifndef TURN_THEN_DRIVE_GOAL_CONTROLLER_TOP_MACROS_SVH
`define TURN_THEN_DRIVE_GOAL_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, reset masked
`define TGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tgc_pkg.sv =====
`default_nettype none

package tgc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int IDX_W        = $clog2(TABLE_LEN);

  localparam int D_W    = 17;   // target minus position
  localparam int CV_W   = 28;   // cordic x, y, z
  localparam int BRG_W  = 17;   // bearing in Q3.13
  localparam int SQ_W   = 34;   // dx^2 + dy^2
  localparam int RT_W   = 17;   // floor sqrt
  localparam int RR_W   = 35;   // root working register
  localparam int K_W    = 5;
  localparam logic [K_W-1:0] SQ_K_START = K_W'(16);

  localparam logic signed [CV_W-1:0] PI_Z = CV_W'(52707179);
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  localparam logic [1:0] PH_TURN    = 2'd0;
  localparam logic [1:0] PH_DRIVE   = 2'd1;
  localparam logic [1:0] PH_ARRIVED = 2'd2;

  localparam logic [2:0] CFG_TARGET_X   = 3'd0;
  localparam logic [2:0] CFG_TARGET_Y   = 3'd1;
  localparam logic [2:0] CFG_DIST_THR   = 3'd2;
  localparam logic [2:0] CFG_ANGLE_THR  = 3'd3;
  localparam logic [2:0] CFG_DIST_GAIN  = 3'd4;
  localparam logic [2:0] CFG_ANGLE_GAIN = 3'd5;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
  } in_t;

  typedef struct packed {
    logic        [14:0] linear_speed;
    logic signed [15:0] angular_speed;
    logic        [1:0]  phase;
  } out_t;

  // atan(2^-i) scaled by 2^24, rounded
  function automatic logic signed [CV_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [CV_W-1:0] v;
    case (idx)
      5'd0:  v = CV_W'(13176795);
      5'd1:  v = CV_W'(7778716);
      5'd2:  v = CV_W'(4110060);
      5'd3:  v = CV_W'(2086331);
      5'd4:  v = CV_W'(1047214);
      5'd5:  v = CV_W'(524117);
      5'd6:  v = CV_W'(262123);
      5'd7:  v = CV_W'(131069);
      5'd8:  v = CV_W'(65536);
      5'd9:  v = CV_W'(32768);
      5'd10: v = CV_W'(16384);
      5'd11: v = CV_W'(8192);
      5'd12: v = CV_W'(4096);
      5'd13: v = CV_W'(2048);
      5'd14: v = CV_W'(1024);
      5'd15: v = CV_W'(512);
      5'd16: v = CV_W'(256);
      5'd17: v = CV_W'(128);
      5'd18: v = CV_W'(64);
      5'd19: v = CV_W'(32);
      5'd20: v = CV_W'(16);
      5'd21: v = CV_W'(8);
      5'd22: v = CV_W'(4);
      5'd23: v = CV_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tgc_cordic.sv =====
`default_nettype none

module tgc_cordic (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [tgc_pkg::D_W-1:0]   dx,
  input  wire logic signed [tgc_pkg::D_W-1:0]   dy,
  output logic                                  done,
  output logic signed [tgc_pkg::BRG_W-1:0]      bearing
);
  import tgc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_STEPS - 1);

  logic signed [CV_W-1:0] x_r, y_r, z_r;
  logic signed [CV_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [CV_W-1:0] x0, y0, xs, ys, at, zr;
  logic [IDX_W-1:0] idx_r;
  logic busy_r, done_r, zero_r;
  logic zero_in;

  assign zero_in = (dx == '0) && (dy == '0);
  assign x0 = {{(CV_W-D_W-8){dx[D_W-1]}}, dx, 8'b0};
  assign y0 = {{(CV_W-D_W-8){dy[D_W-1]}}, dy, 8'b0};

  assign xs = x_r >>> idx_r;
  assign ys = y_r >>> idx_r;
  assign at = atan_lut(idx_r);

  always_comb begin
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !zero_in;
        done_r <= zero_in;
        zero_r <= zero_in;
        idx_r  <= '0;
      end else if (busy_r) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // left half-plane vectors are turned by pi first
  always_ff @(posedge clk) begin
    if (start) begin
      if (dx < 0) begin
        x_r <= -x0;
        y_r <= -y0;
        z_r <= (dy >= 0) ? PI_Z : -PI_Z;
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // round 2^24 radians to Q3.13
  assign zr      = z_r + CV_W'(1024);
  assign bearing = zero_r ? '0 : zr[CV_W-1 -: BRG_W];
  assign done    = done_r;

endmodule

`default_nettype wire

// ===== rtl/tgc_isqrt.sv =====
`default_nettype none

module tgc_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tgc_pkg::SQ_W-1:0]    n,
  output logic                             done,
  output logic [tgc_pkg::RT_W-1:0]         root
);
  import tgc_pkg::*;

  logic [SQ_W-1:0] rem_r, rem_nxt;
  logic [RR_W-1:0] r_r, r_nxt, b, trial;
  logic [K_W-1:0]  k_r;
  logic busy_r, done_r;

  assign b     = RR_W'(1) << {k_r, 1'b0};
  assign trial = r_r + b;

  always_comb begin
    if ({1'b0, rem_r} >= trial) begin
      rem_nxt = rem_r - trial[SQ_W-1:0];
      r_nxt   = (r_r >> 1) + b;
    end else begin
      rem_nxt = rem_r;
      r_nxt   = r_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= SQ_K_START;
      end else if (busy_r) begin
        k_r <= k_r - 1'b1;
        if (k_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= n;
      r_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      r_r   <= r_nxt;
    end
  end

  assign root = r_r[RT_W-1:0];
  assign done = done_r;

endmodule

`default_nettype wire

// ===== rtl/turn_then_drive_goal_controller_top.sv =====
// Turn-then-drive go-to-goal controller.
// Input channel: one pose beat (pos_x, pos_y, heading) on in_valid/in_stall.
// Output channel: one command beat (linear_speed, angular_speed, phase) per
// pose on out_valid/out_stall. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce; unknown indexes are dropped.
// One pose is in flight at a time; in_stall is high from acceptance until the
// command beat has been taken. A turning pose runs the CORDIC and checks the
// heading error: within the angle threshold it turns to driving and goes on,
// else it returns an angular command. A driving pose takes the square root of
// dx^2 + dy^2 and returns an arrived command within the distance threshold,
// else a gain-scaled linear command; an arrived pose returns a zero command.
// A new pose is taken in the cycle after the command beat leaves. The
// vectoring CORDIC (one step per cycle), the bit-per-cycle square root
// (17 steps) and the single shared 18x18 multiplier do the work.
// A stalled result is held in the output register, and no new pose is taken
// until it leaves. Synchronous reset restores the register defaults, sets the
// phase to turning and drops any pose in flight.
`default_nettype none
`include "turn_then_drive_goal_controller_top_macros.svh"

module turn_then_drive_goal_controller_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tgc_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tgc_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_wdata
);
  import tgc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CST  = 4'd1;
  localparam logic [3:0] ST_CORD = 4'd2;
  localparam logic [3:0] ST_ECHK = 4'd3;
  localparam logic [3:0] ST_AOUT = 4'd4;
  localparam logic [3:0] ST_SQX  = 4'd5;
  localparam logic [3:0] ST_SQY  = 4'd6;
  localparam logic [3:0] ST_SQS  = 4'd7;
  localparam logic [3:0] ST_SQRT = 4'd8;
  localparam logic [3:0] ST_LMUL = 4'd9;
  localparam logic [3:0] ST_LOUT = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  // configuration
  logic signed [15:0] tx_r, ty_r;
  logic [15:0] dthr_r, dgain_r, again_r;
  logic [14:0] athr_r;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic signed [D_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [15:0] hd_r, hd_nxt, e_r, e_nxt;
  logic [SQ_W-1:0] acc_r, acc_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_r, prod_nxt, rnd;
  logic signed [23:0] scaled;

  logic cord_start, cord_done, sq_start, sq_done;
  logic signed [BRG_W-1:0] bearing;
  logic [RT_W-1:0] root;
  logic [SQ_W-1:0] sq_n;

  logic signed [17:0] ediff, ewrap;
  logic signed [15:0] ae16;
  logic signed [15:0] ang_sat;
  logic [14:0] lin_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r    <= '0;
      ty_r    <= '0;
      dthr_r  <= 16'd102;
      athr_r  <= 15'd82;
      dgain_r <= 16'd2048;
      again_r <= 16'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_X:   tx_r    <= cfg_wdata;
        CFG_TARGET_Y:   ty_r    <= cfg_wdata;
        CFG_DIST_THR:   dthr_r  <= cfg_wdata;
        CFG_ANGLE_THR:  athr_r  <= cfg_wdata[14:0];
        CFG_DIST_GAIN:  dgain_r <= cfg_wdata;
        CFG_ANGLE_GAIN: again_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tgc_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cord_start),
    .dx      (dx_r),
    .dy      (dy_r),
    .done    (cord_done),
    .bearing (bearing)
  );

  tgc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .n     (sq_n),
    .done  (sq_done),
    .root  (root)
  );

  always_comb begin
    case (state_r)
      ST_ECHK: begin
        mul_a = {2'b00, again_r};
        mul_b = {{2{e_r[15]}}, e_r};
      end
      ST_SQX: begin
        mul_a = {dx_r[D_W-1], dx_r};
        mul_b = {dx_r[D_W-1], dx_r};
      end
      ST_SQY: begin
        mul_a = {dy_r[D_W-1], dy_r};
        mul_b = {dy_r[D_W-1], dy_r};
      end
      ST_LMUL: begin
        mul_a = {2'b00, dgain_r};
        mul_b = {1'b0, root};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // round to nearest at bit 12, then saturate
  assign rnd    = prod_r + 36'sd2048;
  assign scaled = rnd[35:12];

  always_comb begin
    if (scaled > 24'sd32767) begin
      ang_sat = 16'sh7fff;
    end else if (scaled < -24'sd32768) begin
      ang_sat = 16'sh8000;
    end else begin
      ang_sat = scaled[15:0];
    end
    if (scaled > 24'sd32767) begin
      lin_sat = 15'h7fff;
    end else begin
      lin_sat = scaled[14:0];
    end
  end

  // heading error, one wrap step covers every reachable value
  assign ediff = {bearing[BRG_W-1], bearing} - {{2{hd_r[15]}}, hd_r};
  always_comb begin
    if (ediff > PI_Q13) begin
      ewrap = ediff - TWO_PI_Q13;
    end else if (ediff < -PI_Q13) begin
      ewrap = ediff + TWO_PI_Q13;
    end else begin
      ewrap = ediff;
    end
  end

  assign ae16 = e_r[15] ? -e_r : e_r;
  assign sq_n = acc_r + prod_r[SQ_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    hd_nxt        = hd_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cord_start    = 1'b0;
    sq_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dx_nxt = {tx_r[15], tx_r} - {in_data.pos_x[15], in_data.pos_x};
          dy_nxt = {ty_r[15], ty_r} - {in_data.pos_y[15], in_data.pos_y};
          hd_nxt = in_data.heading;
          case (phase_r)
            PH_TURN:  state_nxt = ST_CST;
            PH_DRIVE: state_nxt = ST_SQX;
            default: begin
              out_data_nxt  = '{linear_speed: '0, angular_speed: '0, phase: PH_ARRIVED};
              out_valid_nxt = 1'b1;
              state_nxt     = ST_OUT;
            end
          endcase
        end
      end
      ST_CST: begin
        cord_start = 1'b1;
        state_nxt  = ST_CORD;
      end
      ST_CORD: begin
        if (cord_done) begin
          e_nxt     = ewrap[15:0];
          state_nxt = ST_ECHK;
        end
      end
      ST_ECHK: begin
        if (ae16[14:0] <= athr_r) begin
          phase_nxt = PH_DRIVE;
          state_nxt = ST_SQX;
        end else begin
          state_nxt = ST_AOUT;
        end
      end
      ST_AOUT: begin
        out_data_nxt  = '{linear_speed: '0, angular_speed: ang_sat, phase: PH_TURN};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: begin
        acc_nxt   = prod_r[SQ_W-1:0];
        state_nxt = ST_SQS;
      end
      ST_SQS: begin
        sq_start  = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) begin
          if (root <= {1'b0, dthr_r}) begin
            phase_nxt     = PH_ARRIVED;
            out_data_nxt  = '{linear_speed: '0, angular_speed: '0, phase: PH_ARRIVED};
            out_valid_nxt = 1'b1;
            state_nxt     = ST_OUT;
          end else begin
            state_nxt = ST_LMUL;
          end
        end
      end
      ST_LMUL: state_nxt = ST_LOUT;
      ST_LOUT: begin
        out_data_nxt  = '{linear_speed: lin_sat, angular_speed: '0, phase: PH_DRIVE};
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_TURN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    hd_r       <= hd_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TGC_ASSERT_NEXT(a_arrived_sticky, clk, rst_n, phase_r == PH_ARRIVED,
                   phase_r == PH_ARRIVED, "arrived phase left")
  `TGC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall,
                   in_stall, "pose accepted while busy")
  `TGC_ASSERT_NOW(a_out_busy, clk, rst_n, out_valid,
                  in_stall, "result pending while ready")
  `TGC_ASSERT_NOW(a_turn_no_lin, clk, rst_n, out_valid && out_data.phase != PH_DRIVE,
                  out_data.linear_speed == 15'd0, "linear command outside driving")

endmodule

`default_nettype wire
